### design/ppg_pkg.sv
// Package for the plasma pixel generator: sine table, color constants and register indexes.
package ppg_pkg;

    // Configuration port geometry.
    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 8;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_FRAME_HEIGHT = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] FrameWidthReset  = 8'd64;
    localparam logic [7:0] FrameHeightReset = 8'd32;

    // HSV conversion with saturation and value both at full scale.
    localparam logic [7:0]  Full    = 8'hFF;
    localparam logic [15:0] Chroma  = 16'd65025;
    localparam logic [7:0]  ChanLow = 8'(16'(Full) - (Chroma >> 8));
    localparam logic [2:0]  HueSectors = 3'd6;

    // Hue sector codes.
    localparam logic [2:0] SECTOR_RED_UP     = 3'd0;
    localparam logic [2:0] SECTOR_GREEN_FULL = 3'd1;
    localparam logic [2:0] SECTOR_BLUE_UP    = 3'd2;
    localparam logic [2:0] SECTOR_BLUE_FULL  = 3'd3;
    localparam logic [2:0] SECTOR_RED_RISE   = 3'd4;
    localparam logic [2:0] SECTOR_BLUE_FALL  = 3'd5;

    // One period of a sine wave, offset to 128 and scaled to 8 bits.
    localparam logic [7:0] WAVE_ROM [0:255] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
        8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
        8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
        8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
        8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
        8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
        8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
        8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
        8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
        8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

### design/plasma_pixel_generator_top.sv
// Plasma pixel generator: four-stage pipeline from pixel coordinate to RGB888 color.
//
// One pixel transaction enters per clock while the output is not stalled; the sustained
// rate is one pixel per cycle. The four stages are: squares, row base and
// sine indexes; the four sine table lookups and pixel index add; the hue average and
// sector split; the chroma multiply and channel select into the output register. Each
// stage holds its own valid bit and advances whenever the stage after it is empty or
// moving, so a stalled output fills the bubbles before s_ready drops. frame_width and
// frame_height are written through the cfg_ port and should only change while no pixel
// is in flight; writes to other indexes are ignored.
module plasma_pixel_generator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ppg_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [ppg_pkg::CfgDataWidth-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_pos_x,
    input  logic [7:0]                          s_pos_y,
    input  logic [7:0]                          s_frame_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_red,
    output logic [7:0]                          m_green,
    output logic [7:0]                          m_blue,
    output logic [15:0]                         m_linear_addr,
    output logic                                m_end_of_frame
);

    logic [7:0] frame_width_reg;
    logic [7:0] frame_height_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1
    logic [15:0] xx_reg, yy_reg, row_base_reg;
    logic [7:0]  idx_h_reg, idx_v_reg, idx_d_reg, t1_reg, x1_reg;
    logic        eof1_reg;

    // Stage 2
    logic [7:0]  wave_h_reg, wave_v_reg, wave_d_reg, wave_r_reg;
    logic [15:0] pix2_reg;
    logic        eof2_reg;
    logic [16:0] radial_sum;
    logic [7:0]  idx_r;

    // Stage 3
    logic [2:0]  sector_reg;
    logic [7:0]  frac_reg;
    logic [15:0] pix3_reg;
    logic        eof3_reg;
    logic [9:0]  wave_sum;
    logic [7:0]  hue;
    logic [10:0] hue_scaled;

    // Stage 4
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [15:0] pix4_reg;
    logic        eof4_reg;
    logic [23:0] dn_prod, up_prod;
    logic [7:0]  chan_dn, chan_up;
    logic [7:0]  red_next, green_next, blue_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ppg_pkg::FrameWidthReset;
            frame_height_reg <= ppg_pkg::FrameHeightReset;
        end else if (cfg_wr_en) begin
            if (cfg_index == ppg_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wdata;
            end else if (cfg_index == ppg_pkg::REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_wdata;
            end
        end
    end

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            xx_reg       <= 16'(s_pos_x) * 16'(s_pos_x);
            yy_reg       <= 16'(s_pos_y) * 16'(s_pos_y);
            row_base_reg <= 16'(s_pos_y) * 16'(frame_width_reg);
            idx_h_reg    <= s_pos_x + s_frame_time;
            idx_v_reg    <= s_pos_y + s_frame_time;
            idx_d_reg    <= s_pos_x + s_pos_y + s_frame_time;
            t1_reg       <= s_frame_time;
            x1_reg       <= s_pos_x;
            eof1_reg     <= (s_pos_x == 8'(frame_width_reg - 8'd1))
                         && (s_pos_y == 8'(frame_height_reg - 8'd1));
        end
    end

    // Only bits 11:4 of the squared radius survive the wrap to 8 bits.
    assign radial_sum = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign idx_r      = radial_sum[11:4] + t1_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            wave_h_reg <= ppg_pkg::WAVE_ROM[idx_h_reg];
            wave_v_reg <= ppg_pkg::WAVE_ROM[idx_v_reg];
            wave_d_reg <= ppg_pkg::WAVE_ROM[idx_d_reg];
            wave_r_reg <= ppg_pkg::WAVE_ROM[idx_r];
            pix2_reg   <= row_base_reg + 16'(x1_reg);
            eof2_reg   <= eof1_reg;
        end
    end

    assign wave_sum   = 10'(wave_h_reg) + 10'(wave_v_reg) + 10'(wave_d_reg) + 10'(wave_r_reg);
    assign hue        = wave_sum[9:2];
    assign hue_scaled = 11'(hue) * 11'(ppg_pkg::HueSectors);

    always_ff @(posedge aclk) begin
        if (en3) begin
            sector_reg <= hue_scaled[10:8];
            frac_reg   <= hue_scaled[7:0];
            pix3_reg   <= pix2_reg;
            eof3_reg   <= eof2_reg;
        end
    end

    assign dn_prod = 24'(ppg_pkg::Chroma) * 24'(frac_reg);
    assign up_prod = 24'(ppg_pkg::Chroma) * 24'(ppg_pkg::Full - frac_reg);
    assign chan_dn = ppg_pkg::Full - dn_prod[23:16];
    assign chan_up = ppg_pkg::Full - up_prod[23:16];

    always_comb begin
        case (sector_reg)
            ppg_pkg::SECTOR_RED_UP: begin
                red_next   = ppg_pkg::Full;
                green_next = chan_up;
                blue_next  = ppg_pkg::ChanLow;
            end
            ppg_pkg::SECTOR_GREEN_FULL: begin
                red_next   = chan_dn;
                green_next = ppg_pkg::Full;
                blue_next  = ppg_pkg::ChanLow;
            end
            ppg_pkg::SECTOR_BLUE_UP: begin
                red_next   = ppg_pkg::ChanLow;
                green_next = ppg_pkg::Full;
                blue_next  = chan_up;
            end
            ppg_pkg::SECTOR_BLUE_FULL: begin
                red_next   = ppg_pkg::ChanLow;
                green_next = chan_dn;
                blue_next  = ppg_pkg::Full;
            end
            ppg_pkg::SECTOR_RED_RISE: begin
                red_next   = chan_up;
                green_next = ppg_pkg::ChanLow;
                blue_next  = ppg_pkg::Full;
            end
            default: begin
                red_next   = ppg_pkg::Full;
                green_next = ppg_pkg::ChanLow;
                blue_next  = chan_dn;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            pix4_reg  <= pix3_reg;
            eof4_reg  <= eof3_reg;
        end
    end

    assign m_valid        = v4_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_linear_addr  = pix4_reg;
    assign m_end_of_frame = eof4_reg;

    // An empty output stage must never block the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v4_reg |-> s_ready)
        else $error("input stalled while the output stage is empty");

    // An accepted transaction always lands in the first stage.
    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction lost at stage 1");

    // The hue never scales past the last sector.
    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (sector_reg <= ppg_pkg::SECTOR_BLUE_FALL))
        else $error("hue sector out of range");

    // With full saturation and value one channel is always at full scale.
    a_one_full_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red == 8'hFF || m_green == 8'hFF || m_blue == 8'hFF))
        else $error("no color channel at full scale");

endmodule

### bench/tb.sv
// Self-checking testbench for the plasma pixel generator: directed table plus random scans.
`timescale 1ns / 100ps

module tb;

    localparam int DirectedCount = 24;
    localparam int RandomPhases  = 8;
    localparam int ItemsPerPhase = 106;
    localparam int DrainSlack    = 8;
    localparam int WatchdogLimit = 1000;
    localparam int ChromaFull    = 255 * 255;
    localparam int FullScale     = 255;
    localparam int CfgIndexBits  = ppg_pkg::CfgIndexWidth;
    localparam int CfgDataBits   = ppg_pkg::CfgDataWidth;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] linear_addr;
        logic        end_of_frame;
    } pixel_result_t;

    typedef struct packed {
        logic [7:0]    w;
        logic [7:0]    h;
        logic [7:0]    x;
        logic [7:0]    y;
        logic [7:0]    t;
        logic          typed;
        pixel_result_t res;
    } directed_row_t;

    localparam pixel_result_t NoColor = '0;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [CfgIndexBits-1:0] cfg_index = '0;
    logic [CfgDataBits-1:0]  cfg_wdata = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pos_x        = '0;
    logic [7:0]  s_pos_y        = '0;
    logic [7:0]  s_frame_time   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [15:0] m_linear_addr;
    logic        m_end_of_frame;

    logic [7:0]    frame_w = ppg_pkg::FrameWidthReset;
    logic [7:0]    frame_h = ppg_pkg::FrameHeightReset;
    pixel_result_t pending_pixels [$];
    int            error_count  = 0;
    int            quiet_cycles = 0;
    int            sink_stall   = 0;
    bit            steady_flow  = 1'b0;

    // Rows whose color is worked out by hand carry it; the rest use the model below.
    directed_row_t directed_rows [DirectedCount] = '{
        '{8'd64,  8'd32,  8'd0,   8'd0,   8'd0,   1'b1, '{8'd1, 8'd255, 8'd255, 16'd0, 1'b0}},
        '{8'd64,  8'd32,  8'd63,  8'd31,  8'd0,   1'b1, '{8'd255, 8'd1, 8'd127, 16'd2047, 1'b1}},
        '{8'd64,  8'd32,  8'd63,  8'd31,  8'd255, 1'b0, NoColor},
        '{8'd64,  8'd32,  8'd254, 8'd254, 8'd255, 1'b0, NoColor},
        '{8'd64,  8'd32,  8'd0,   8'd31,  8'd128, 1'b0, NoColor},
        '{8'd64,  8'd32,  8'd63,  8'd0,   8'd77,  1'b0, NoColor},
        '{8'd64,  8'd32,  8'd10,  8'd20,  8'd64,  1'b0, NoColor},
        '{8'd64,  8'd32,  8'd30,  8'd5,   8'd192, 1'b0, NoColor},
        '{8'd255, 8'd255, 8'd254, 8'd254, 8'd0,   1'b0, NoColor},
        '{8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 1'b0, NoColor},
        '{8'd255, 8'd255, 8'd254, 8'd0,   8'd200, 1'b0, NoColor},
        '{8'd255, 8'd255, 8'd0,   8'd254, 8'd1,   1'b0, NoColor},
        '{8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd1, 8'd255, 8'd255, 16'd0, 1'b1}},
        '{8'd1,   8'd1,   8'd1,   8'd1,   8'd9,   1'b0, NoColor},
        '{8'd1,   8'd1,   8'd0,   8'd5,   8'd30,  1'b0, NoColor},
        '{8'd0,   8'd0,   8'd254, 8'd254, 8'd13,  1'b0, NoColor},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd1, 8'd255, 8'd255, 16'd0, 1'b0}},
        '{8'd0,   8'd64,  8'd200, 8'd10,  8'd100, 1'b0, NoColor},
        '{8'd0,   8'd64,  8'd170, 8'd63,  8'd85,  1'b0, NoColor},
        '{8'd17,  8'd0,   8'd16,  8'd254, 8'd41,  1'b0, NoColor},
        '{8'd17,  8'd0,   8'd16,  8'd3,   8'd41,  1'b0, NoColor},
        '{8'd64,  8'd32,  8'd85,  8'd170, 8'd170, 1'b0, NoColor},
        '{8'd255, 8'd1,   8'd254, 8'd0,   8'd51,  1'b0, NoColor},
        '{8'd1,   8'd255, 8'd0,   8'd254, 8'd204, 1'b0, NoColor}
    };

    plasma_pixel_generator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_frame_time  (s_frame_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_linear_addr (m_linear_addr),
        .m_end_of_frame(m_end_of_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Color, index and end-of-frame flag of one pixel under the current frame size.
    function automatic pixel_result_t shade_pixel(input logic [7:0] x, y, t);
        logic [7:0]    idx_h, idx_v, idx_d, idx_r;
        logic [16:0]   radius_sq;
        logic [9:0]    wave_sum;
        logic [7:0]    hue;
        logic [10:0]   scaled;
        logic [7:0]    frac, lo, dn, up;
        logic [2:0]    sector;
        pixel_result_t res;
        idx_h     = x + t;
        idx_v     = y + t;
        idx_d     = x + y + t;
        radius_sq = 17'(x) * 17'(x) + 17'(y) * 17'(y);
        idx_r     = radius_sq[11:4] + t;
        wave_sum  = 10'(ppg_pkg::WAVE_ROM[idx_h]) + 10'(ppg_pkg::WAVE_ROM[idx_v])
                  + 10'(ppg_pkg::WAVE_ROM[idx_d]) + 10'(ppg_pkg::WAVE_ROM[idx_r]);
        hue       = wave_sum[9:2];
        scaled    = 11'(hue) * 11'd6;
        sector    = scaled[10:8];
        frac      = scaled[7:0];
        lo        = 8'(FullScale - (ChromaFull >> 8));
        dn        = 8'(FullScale - ((ChromaFull * int'(frac)) >> 16));
        up        = 8'(FullScale - ((ChromaFull * (255 - int'(frac))) >> 16));
        case (sector)
            ppg_pkg::SECTOR_RED_UP: begin
                res.red = 8'd255; res.green = up;     res.blue = lo;
            end
            ppg_pkg::SECTOR_GREEN_FULL: begin
                res.red = dn;     res.green = 8'd255; res.blue = lo;
            end
            ppg_pkg::SECTOR_BLUE_UP: begin
                res.red = lo;     res.green = 8'd255; res.blue = up;
            end
            ppg_pkg::SECTOR_BLUE_FULL: begin
                res.red = lo;     res.green = dn;     res.blue = 8'd255;
            end
            ppg_pkg::SECTOR_RED_RISE: begin
                res.red = up;     res.green = lo;     res.blue = 8'd255;
            end
            default: begin
                res.red = 8'd255; res.green = lo;     res.blue = dn;
            end
        endcase
        res.linear_addr  = 16'(y) * 16'(frame_w) + 16'(x);
        res.end_of_frame = (x == 8'(frame_w - 8'd1)) && (y == 8'(frame_h - 8'd1));
        return res;
    endfunction

    task automatic send_pixel(input logic [7:0] x, y, t, input logic typed,
                              input pixel_result_t typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pos_x      <= x;
        s_pos_y      <= y;
        s_frame_time <= t;
        do @(posedge aclk); while (!s_ready);
        pending_pixels.push_back(typed ? typed_res : shade_pixel(x, y, t));
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DrainSlack) @(posedge aclk);
    endtask

    // A write to an unused index follows every pair; it must leave both registers alone.
    task automatic set_frame_size(input logic [7:0] w, h);
        cfg_wr_en <= 1'b1;
        cfg_index <= ppg_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= ppg_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_index <= CfgIndexBits'($urandom_range(2, 255));
        cfg_wdata <= CfgDataBits'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    always @(posedge aclk) begin
        if (sink_stall != 0) begin
            m_ready    <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_ready    <= 1'b1;
            sink_stall <= pick_gap();
        end
    end

    always @(posedge aclk) begin : check_pixels
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected pixel transaction: r=%0d g=%0d b=%0d idx=%0d eof=%0d",
                             m_red, m_green, m_blue, m_linear_addr, m_end_of_frame);
                end
            end else begin
                want = pending_pixels.pop_front();
                if (m_red !== want.red || m_green !== want.green || m_blue !== want.blue
                        || m_linear_addr !== want.linear_addr
                        || m_end_of_frame !== want.end_of_frame) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("pixel mismatch: expected r=%0d g=%0d b=%0d idx=%0d eof=%0d",
                                 want.red, want.green, want.blue, want.linear_addr,
                                 want.end_of_frame);
                        $display("                got      r=%0d g=%0d b=%0d idx=%0d eof=%0d",
                                 m_red, m_green, m_blue, m_linear_addr, m_end_of_frame);
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] w, h, x, y, t;
        logic [7:0] scan_x, scan_y, scan_t;
        int         r;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].w != frame_w || directed_rows[i].h != frame_h) begin
                drain_pipeline();
                set_frame_size(directed_rows[i].w, directed_rows[i].h);
            end
            send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].t,
                       directed_rows[i].typed, directed_rows[i].res);
        end

        for (int phase = 0; phase < RandomPhases; phase++) begin
            case (phase)
                0: begin w = 8'd255; h = 8'd255; end
                1: begin w = 8'd1;   h = 8'd1;   end
                2: begin w = ppg_pkg::FrameWidthReset; h = ppg_pkg::FrameHeightReset; end
                3: begin w = 8'd1;   h = 8'd255; end
                4: begin w = 8'd255; h = 8'd1;   end
                default: begin
                    w = 8'($urandom_range(1, 255));
                    h = 8'($urandom_range(1, 255));
                end
            endcase
            drain_pipeline();
            set_frame_size(w, h);
            steady_flow = (phase % 3 == 2);
            scan_x = 8'($urandom_range(0, int'(w) - 1));
            scan_y = 8'($urandom_range(0, int'(h) - 1));
            scan_t = 8'($urandom);
            for (int n = 0; n < ItemsPerPhase; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    // Raster scan with one frame time per frame, as a panel refresh would send.
                    x = scan_x;
                    y = scan_y;
                    t = scan_t;
                    if (scan_x == 8'(w - 8'd1)) begin
                        scan_x = 8'd0;
                        if (scan_y == 8'(h - 8'd1)) begin
                            scan_y = 8'd0;
                            scan_t = scan_t + 8'd1;
                        end else begin
                            scan_y = scan_y + 8'd1;
                        end
                    end else begin
                        scan_x = scan_x + 8'd1;
                    end
                end else if (r < 70) begin
                    x = 8'($urandom_range(0, int'(w) - 1));
                    y = 8'($urandom_range(0, int'(h) - 1));
                    t = 8'($urandom);
                end else if (r < 80) begin
                    x = 8'(w - 8'd1);
                    y = 8'(h - 8'd1);
                    t = 8'($urandom);
                end else begin
                    x = 8'($urandom_range(0, 254));
                    y = 8'($urandom_range(0, 254));
                    t = 8'($urandom);
                end
                send_pixel(x, y, t, 1'b0, NoColor);
            end
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### plasma_pixel_generator_top.f
design/ppg_pkg.sv
design/plasma_pixel_generator_top.sv
bench/tb.sv
